>>> rtl/cobs_stream_encoder_top_assert.svh
// Assertion macros used by the encoder datapath RTL
`ifndef COBS_STREAM_ENCODER_TOP_ASSERT_SVH
`define COBS_STREAM_ENCODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define COBS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("cobs encoder: assertion failed");

`define COBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cobs encoder: assertion failed");

`else

`define COBS_ASSERT(lbl, clk, rst_n, prop)

`define COBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/cobs_enc_pkg.sv
// Types and constants of the COBS stream encoder
`default_nettype none

package cobs_enc_pkg;

	localparam int RUN_MAX   = 254;
	localparam int LANES     = 4;
	localparam int ROWS      = 64;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int POS_W     = 9;

	localparam logic [7:0] TRAIL_CODE = 8'h01;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_en;
		logic load;
	} cobs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit_req;
		logic last_chunk;
		logic out_free;
	} cobs_status_t;

endpackage

`default_nettype wire

>>> rtl/cobs_enc_ctrl.sv
// Controller state machine of the COBS stream encoder
`default_nettype none

module cobs_enc_ctrl
	import cobs_enc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire cobs_status_t status,
	output cobs_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.accept = in_valid && in_ready;
		cmd.rd_en  = (state_q == ST_READ);
		cmd.load   = (state_q == ST_LOAD) && status.out_free;
		state_d    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && status.emit_req)
					state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// hold until the output register can take the chunk
				if (status.out_free)
					state_d = status.last_chunk ? ST_IDLE : ST_READ;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

>>> rtl/cobs_enc_dp.sv
// Datapath of the COBS stream encoder: run store, chunk builder, output register
`default_nettype none

`include "cobs_stream_encoder_top_assert.svh"

module cobs_enc_dp
	import cobs_enc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic [7:0] data_byte,
	input  wire logic      frame_end,
	input  wire cobs_cmd_t cmd,
	output cobs_status_t   status,
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [7:0]     out_byte0,
	output logic [7:0]     out_byte1,
	output logic [7:0]     out_byte2,
	output logic [7:0]     out_byte3,
	output logic [2:0]     byte_count,
	output logic           last_of_run
);

	// run store, one row holds four consecutive run bytes
	logic [LANES-1:0][7:0] mem_q [0:ROWS-1];
	logic [LANES-1:0][7:0] rd_data_q;

	logic [7:0]       run_len_q;
	logic [7:0]       flush_len_q;
	logic [7:0]       code_q;
	logic             trail_q;
	logic [POS_W-1:0] total_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       carry_q;

	logic             out_valid_q;
	logic [LANES-1:0][7:0] obyte_q;
	logic [2:0]       cnt_q;
	logic             last_q;

	logic             byte_zero;
	logic [7:0]       len_inc;
	logic             run_full;
	logic             emit_req;
	logic [7:0]       flush_len_d;
	logic             trail_d;

	logic [POS_W-1:0] remain;
	logic [2:0]       chunk_cnt;
	logic             chunk_last;
	logic [LANES-1:0][7:0] chunk;
	logic [POS_W-1:0] flush_end;

	always_comb begin
		byte_zero   = (data_byte == 8'd0);
		len_inc     = run_len_q + 8'd1;
		run_full    = !byte_zero && (len_inc == 8'(RUN_MAX));
		emit_req    = byte_zero || run_full || frame_end;
		flush_len_d = byte_zero ? run_len_q : len_inc;
		trail_d     = frame_end && (byte_zero || run_full);
	end

	// chunk at pos_q: code byte, run bytes, then the trailing code if any
	always_comb begin
		remain     = total_q - pos_q;
		chunk_last = (remain <= POS_W'(LANES));
		chunk_cnt  = chunk_last ? remain[2:0] : 3'(LANES);
		flush_end  = {1'b0, flush_len_q};
		for (int j = 0; j < LANES; j++) begin
			logic [POS_W-1:0] p;
			logic [7:0]       src;
			p   = pos_q + POS_W'(j);
			src = (j == 0) ? carry_q : rd_data_q[(j == 0) ? 0 : j - 1];
			if (p == '0)
				chunk[j] = code_q;
			else if (p <= flush_end)
				chunk[j] = src;
			else if (trail_q && (p == flush_end + POS_W'(1)))
				chunk[j] = TRAIL_CODE;
			else
				chunk[j] = 8'd0;
		end
	end

	always_comb begin
		status.emit_req   = emit_req;
		status.last_chunk = chunk_last;
		status.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !byte_zero)
			mem_q[run_len_q[ROW_W+1:2]][run_len_q[1:0]] <= data_byte;
		if (cmd.rd_en)
			rd_data_q <= mem_q[pos_q[ROW_W+1:2]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q <= 8'd0;
		end else if (cmd.accept) begin
			run_len_q <= emit_req ? 8'd0 : len_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			flush_len_q <= flush_len_d;
			code_q      <= flush_len_d + 8'd1;
			trail_q     <= trail_d;
			total_q     <= POS_W'(1) + {1'b0, flush_len_d} + POS_W'(trail_d);
			pos_q       <= '0;
		end else if (cmd.load) begin
			pos_q   <= pos_q + POS_W'(LANES);
			// keep the top lane: it opens the next chunk
			carry_q <= rd_data_q[LANES-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			obyte_q <= chunk;
			cnt_q   <= chunk_cnt;
			last_q  <= chunk_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte0   = obyte_q[0];
	assign out_byte1   = obyte_q[1];
	assign out_byte2   = obyte_q[2];
	assign out_byte3   = obyte_q[3];
	assign byte_count  = cnt_q;
	assign last_of_run = last_q;

	`COBS_ASSERT(a_run_len_bound, clk, arst_n, run_len_q < 8'(RUN_MAX))
	`COBS_ASSERT(a_count_range, clk, arst_n, !out_valid_q || (cnt_q != 3'd0 && cnt_q <= 3'(LANES)))
	`COBS_ASSERT_NEXT(a_pos_inside, clk, arst_n, cmd.load && !chunk_last, pos_q < total_q)
	`COBS_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.load, out_valid_q)

endmodule

`default_nettype wire

>>> rtl/cobs_stream_encoder_top.sv
// Top level of the COBS stream encoder
// Input channel: one raw frame byte per request (data_byte) with frame_end on the
// last byte of a frame; in_valid/in_ready handshake.
// Output channel: encoded bytes packed four per request (out_byte0..3), byte_count
// valid bytes in order, last_of_run on the final chunk caused by one input byte.
// The caller appends the zero delimiter after each frame.
// A byte that emits nothing is accepted and in_ready stays high.
// A byte that flushes a run (zero byte, 254th run byte or frame end) is accepted,
// then each output chunk passes a read step, which fetches a four-byte row
// of the run store (single read port), and a load step into the output register.
// A full 254-byte run gives 64 chunks. in_ready is low until the last chunk is loaded.
// A stalled receiver holds the output register; the encoder waits in its load
// step and no chunk is lost. The next input byte is taken while the last chunk
// still waits.
// Reset clears the pending run and the output valid flag; the run store itself
// needs no clearing, only written entries are ever shown.
`default_nettype none

module cobs_stream_encoder_top
	import cobs_enc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_end,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte0,
	output logic [7:0]      out_byte1,
	output logic [7:0]      out_byte2,
	output logic [7:0]      out_byte3,
	output logic [2:0]      byte_count,
	output logic            last_of_run
);

	cobs_cmd_t    cmd;
	cobs_status_t status;

	cobs_enc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	cobs_enc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.frame_end   (frame_end),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte0   (out_byte0),
		.out_byte1   (out_byte1),
		.out_byte2   (out_byte2),
		.out_byte3   (out_byte3),
		.byte_count  (byte_count),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_cobs_stream_encoder_top.sv
// Self-checking testbench for the COBS stream encoder top level
`timescale 1ns / 100ps
`default_nettype none

module tb_cobs_stream_encoder_top
	import cobs_enc_pkg::*;
();

	typedef struct packed {
		logic [3:0][7:0] lanes;
		logic [2:0]      count;
		logic            last;
	} chunk_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       frame_end = 1'b0;
	logic       out_ready = 1'b0;
	wire logic       in_ready;
	wire logic       out_valid;
	wire logic [7:0] out_byte0;
	wire logic [7:0] out_byte1;
	wire logic [7:0] out_byte2;
	wire logic [7:0] out_byte3;
	wire logic [2:0] byte_count;
	wire logic       last_of_run;

	bit          jitter_on = 1'b1;
	int unsigned mismatches = 0;

	// encoder model state and the chunks still owed by the block
	logic [7:0]  run_buf [RUN_MAX];
	int unsigned run_len = 0;
	logic [7:0]  code_stream [$];
	chunk_t      encoded_chunks [$];

	cobs_stream_encoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte0   (out_byte0),
		.out_byte1   (out_byte1),
		.out_byte2   (out_byte2),
		.out_byte3   (out_byte3),
		.byte_count  (byte_count),
		.last_of_run (last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic void flush_run();
		code_stream.push_back(8'(run_len + 1));
		for (int i = 0; i < run_len; i++)
			code_stream.push_back(run_buf[i]);
		run_len = 0;
	endfunction

	// Work out the chunks one accepted byte causes and queue them
	function automatic void encode_byte(logic [7:0] b, logic fe);
		chunk_t c;
		int     n;
		code_stream.delete();
		if (b == 8'h00) begin
			flush_run();
		end else begin
			run_buf[run_len] = b;
			run_len++;
			if (run_len == RUN_MAX)
				flush_run();
		end
		if (fe)
			flush_run();
		while (code_stream.size() > 0) begin
			n = (code_stream.size() > 4) ? 4 : code_stream.size();
			c = '0;
			c.count = 3'(n);
			for (int k = 0; k < n; k++)
				c.lanes[k] = code_stream.pop_front();
			c.last = (code_stream.size() == 0);
			encoded_chunks.push_back(c);
		end
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : chunk_check
		chunk_t want;
		if (arst_n && out_valid && out_ready) begin
			if (encoded_chunks.size() == 0) begin
				mismatches++;
				$display("%0t: chunk with none expected, bytes %h %h %h %h count %0d last %0b",
					$time, out_byte0, out_byte1, out_byte2, out_byte3, byte_count,
					last_of_run);
			end else begin
				want = encoded_chunks.pop_front();
				check_field("out_byte0", want.lanes[0], out_byte0);
				check_field("out_byte1", want.lanes[1], out_byte1);
				check_field("out_byte2", want.lanes[2], out_byte2);
				check_field("out_byte3", want.lanes[3], out_byte3);
				check_field("byte_count", want.count, byte_count);
				check_field("last_of_run", want.last, last_of_run);
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= !jitter_on || ($urandom_range(0, 99) >= 22);
	end

	// Offer one byte and hold it until the request is taken
	task automatic send_byte(input logic [7:0] b, input logic fe);
		if (jitter_on) begin
			while ($urandom_range(0, 99) < 22) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		frame_end <= fe;
		do
			@(posedge clk);
		while (!in_ready);
		encode_byte(b, fe);
	endtask

	task automatic send_run(input int n, input bit close_frame);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom_range(1, 255)), close_frame && (i == n - 1));
	endtask

	// Hold the sender off until every owed chunk has come out
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (encoded_chunks.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_short_frames();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b1);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h33, 1'b0);
		send_byte(8'h44, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAA, 1'b1);
	endtask

	task automatic test_zero_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		// frame ending in zero: trailing single code
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA5, 1'b1);
	endtask

	task automatic test_full_runs();
		jitter_on = 1'b0;
		// full run closing the frame: most chunks from one byte
		send_run(RUN_MAX, 1'b1);
		wait_drain();
		jitter_on = 1'b1;
	endtask

	task automatic test_random_frames();
		int sent;
		int len;
		int zero_pct;
		sent = 0;
		while (sent < 120) begin
			if ($urandom_range(0, 24) == 0)
				len = $urandom_range(20, 40);
			else
				len = $urandom_range(1, 12);
			case ($urandom_range(0, 4))
				0: zero_pct = 0;
				1: zero_pct = 5;
				2: zero_pct = 25;
				3: zero_pct = 60;
				default: zero_pct = 100;
			endcase
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < zero_pct)
					send_byte(8'h00, i == len - 1);
				else
					send_byte(8'($urandom_range(1, 255)), i == len - 1);
			end
			sent += len;
			if ($urandom_range(0, 9) == 0)
				wait_drain();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_frames();
		test_zero_bytes();
		wait_drain();
		test_full_runs();
		test_random_frames();
		in_valid <= 1'b0;
		while (encoded_chunks.size() != 0)
			@(posedge clk);
		// catch any stray chunk after the last one owed
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
